// ----- sv/rld_pkg.sv -----
package rld_pkg;

	localparam int IDX_W       = 9;
	localparam int COORD_W     = 32;
	localparam int TAG_W       = 32;
	localparam int STAT_W      = 2;
	localparam int DEPTH_DEF   = 256;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [IDX_W-1:0] CAP_RESET = IDX_W'(256);

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_QUERY,
		OP_APPEND
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_APPENDED = 2'd0,
		ST_OVERLAP  = 2'd1,
		ST_FULL     = 2'd2,
		ST_CLEARED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_DECIDE,
		B_RESULT
	} back_st_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] bottom;
	} rect_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] first_idx;
		logic [IDX_W-1:0] end_idx;
		logic             mark;
		rect_t            rect;
		logic [TAG_W-1:0] tag_a;
		logic [TAG_W-1:0] tag_b;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] slot;
		logic             carried;
	} rsp_t;

endpackage

// ----- sv/rld_if.sv -----
interface rld_req_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic [rld_pkg::IDX_W-1:0]           start_index;
	logic [rld_pkg::IDX_W-1:0]           end_index;
	logic                                mark_flag;
	logic signed [rld_pkg::COORD_W-1:0]  query_left;
	logic signed [rld_pkg::COORD_W-1:0]  query_top;
	logic signed [rld_pkg::COORD_W-1:0]  query_right;
	logic signed [rld_pkg::COORD_W-1:0]  query_bottom;
	logic signed [rld_pkg::TAG_W-1:0]    tag_first;
	logic signed [rld_pkg::TAG_W-1:0]    tag_second;

	modport source (
		output valid, req_type, start_index, end_index, mark_flag,
		output query_left, query_top, query_right, query_bottom, tag_first, tag_second,
		input ready
	);
	modport sink (
		input valid, req_type, start_index, end_index, mark_flag,
		input query_left, query_top, query_right, query_bottom, tag_first, tag_second,
		output ready
	);
endinterface

interface rld_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [rld_pkg::STAT_W-1:0] status;
	logic [rld_pkg::IDX_W-1:0]  slot_index;
	logic                       carried_flag;

	modport source (output valid, status, slot_index, carried_flag, input ready);
	modport sink (input valid, status, slot_index, carried_flag, output ready);
endinterface

// ----- sv/rld_front.sv -----
module rld_front (
	input  logic          clk,
	input  logic          arst_n,
	rld_req_if.sink       req,
	output rld_pkg::req_t item,
	output logic          item_valid,
	input  logic          item_ready
);
	import rld_pkg::*;

	req_t item_s1;
	logic v_s1;
	op_t  op_c;
	logic take;

	always_comb begin
		priority if (req.req_type) begin
			op_c = OP_CLEAR;
		end else if (req.start_index >= req.end_index) begin
			op_c = OP_APPEND;
		end else begin
			op_c = OP_QUERY;
		end
	end

	assign req.ready = !v_s1 || item_ready;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (item_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op          <= op_c;
			item_s1.first_idx   <= req.start_index;
			item_s1.end_idx     <= req.end_index;
			item_s1.mark        <= req.mark_flag;
			item_s1.rect.left   <= req.query_left;
			item_s1.rect.top    <= req.query_top;
			item_s1.rect.right  <= req.query_right;
			item_s1.rect.bottom <= req.query_bottom;
			item_s1.tag_a       <= req.tag_first;
			item_s1.tag_b       <= req.tag_second;
		end
	end

	assign item       = item_s1;
	assign item_valid = v_s1;

endmodule

// ----- sv/rld_queue.sv -----
module rld_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  rld_pkg::req_t push_item,
	output logic          pop_valid,
	input  logic          pop_ready,
	output rld_pkg::req_t pop_item
);
	import rld_pkg::*;

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	req_t          mem_q [QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [FW-1:0] fill_q;
	logic          push;
	logic          pop;

	function automatic logic [QW-1:0] ptr_next(input logic [QW-1:0] ptr);
		logic [QW-1:0] res;
		if (ptr == QW'(QUEUE_DEPTH - 1)) begin
			res = '0;
		end else begin
			res = ptr + 1'b1;
		end
		return res;
	endfunction

	assign push_ready = fill_q != FW'(QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(QUEUE_DEPTH)) else $error("queue fill above depth");
	a_fill_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> fill_q == $past(fill_q) + 1'b1) else $error("push lost");
	a_fill_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> fill_q == $past(fill_q) - 1'b1) else $error("pop lost");

endmodule

// ----- sv/rld_back.sv -----
module rld_back #(
	parameter int TABLE_DEPTH = rld_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rld_pkg::IDX_W-1:0] cfg_wdata,
	input  logic                      pop_valid,
	output logic                      pop_ready,
	input  rld_pkg::req_t             pop_item,
	rld_rsp_if.source                 rsp
);
	import rld_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	rect_t            rect_mem [TABLE_DEPTH];
	logic [2*TAG_W-1:0] tag_mem [TABLE_DEPTH];
	logic             flag_lo_mem [TABLE_DEPTH];
	logic             flag_hi_mem [TABLE_DEPTH];

	back_st_t         st_q;
	back_st_t         st_d;
	logic [IDX_W-1:0] cap_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] rd_q;
	logic [IDX_W-1:0] end_q;
	logic             carried_q;
	rect_t            rect_q;
	logic [TAG_W-1:0] tag_a_q;
	logic [TAG_W-1:0] tag_b_q;
	rsp_t             res_q;
	rsp_t             out_q;
	logic             out_v_q;
	rect_t            rd_rect_s1;
	logic             chk_v_s1;
	logic [IDX_W-1:0] chk_idx_s1;

	logic [IDX_W-1:0] end_clamp;
	logic             disjoint;
	logic             exact;
	logic             defer;
	logic             match;
	logic             full;
	logic             out_free;
	logic             issue;
	logic             append_we;
	logic             load_out;
	logic             take;

	function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
		logic [AW+IDX_W-1:0] ext;
		ext = {{AW{1'b0}}, idx};
		return ext[AW-1:0];
	endfunction

	assign end_clamp = (pop_item.end_idx > cnt_q) ? cnt_q : pop_item.end_idx;
	assign disjoint  = ($signed(rd_rect_s1.right) <= $signed(rect_q.left))
		|| ($signed(rd_rect_s1.bottom) <= $signed(rect_q.top))
		|| ($signed(rd_rect_s1.left) >= $signed(rect_q.right))
		|| ($signed(rd_rect_s1.top) >= $signed(rect_q.bottom));
	assign exact     = rd_rect_s1 == rect_q;
	assign defer     = (st_q == B_SCAN) && chk_v_s1 && !disjoint && !exact;
	assign match     = (st_q == B_SCAN) && chk_v_s1 && !disjoint && exact;
	assign full      = (cnt_q >= cap_q) || (32'(cnt_q) >= 32'(TABLE_DEPTH));
	assign out_free  = !out_v_q || rsp.ready;
	assign take      = pop_valid && pop_ready;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			B_IDLE: begin
				if (pop_valid) begin
					unique case (pop_item.op)
						OP_CLEAR: st_d = B_RESULT;
						OP_QUERY: st_d = (pop_item.first_idx < end_clamp) ? B_SCAN : B_DECIDE;
						default:  st_d = B_DECIDE;
					endcase
				end
			end
			B_SCAN: begin
				if (defer) begin
					st_d = B_RESULT;
				end else if (rd_q >= end_q) begin
					st_d = B_DECIDE;
				end
			end
			B_DECIDE: st_d = B_RESULT;
			B_RESULT: begin
				if (out_free) begin
					st_d = B_IDLE;
				end
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = st_q == B_IDLE;
		issue     = (st_q == B_SCAN) && (rd_q < end_q) && !defer;
		append_we = (st_q == B_DECIDE) && !full;
		load_out  = (st_q == B_RESULT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= B_IDLE;
			cap_q    <= CAP_RESET;
			cnt_q    <= '0;
			out_v_q  <= 1'b0;
			chk_v_s1 <= 1'b0;
		end else begin
			st_q     <= st_d;
			chk_v_s1 <= issue;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (take && pop_item.op == OP_CLEAR) begin
				cnt_q <= '0;
			end else if (append_we) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rect_q         <= pop_item.rect;
			tag_a_q        <= pop_item.tag_a;
			tag_b_q        <= pop_item.tag_b;
			end_q          <= end_clamp;
			rd_q           <= pop_item.first_idx;
			carried_q      <= pop_item.mark;
			res_q.status   <= ST_CLEARED;
			res_q.slot     <= '0;
			res_q.carried  <= 1'b0;
		end
		if (issue) begin
			rd_q       <= rd_q + 1'b1;
			chk_idx_s1 <= rd_q;
		end
		if (match) begin
			carried_q <= 1'b1;
		end
		if (defer) begin
			res_q.status  <= ST_OVERLAP;
			res_q.slot    <= chk_idx_s1;
			res_q.carried <= carried_q;
		end
		if (st_q == B_DECIDE) begin
			res_q.status  <= full ? ST_FULL : ST_APPENDED;
			res_q.slot    <= full ? end_q : cnt_q;
			res_q.carried <= carried_q;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (append_we) begin
			rect_mem[to_addr(cnt_q)]    <= rect_q;
			tag_mem[to_addr(cnt_q)]     <= {tag_a_q, tag_b_q};
			flag_lo_mem[to_addr(cnt_q)] <= 1'b1;
			flag_hi_mem[to_addr(cnt_q)] <= carried_q;
		end
		if (match) begin
			flag_hi_mem[to_addr(chk_idx_s1)] <= 1'b1;
		end
		if (issue) begin
			rd_rect_s1 <= rect_mem[to_addr(rd_q)];
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.status       = out_q.status;
	assign rsp.slot_index   = out_q.slot;
	assign rsp.carried_flag = out_q.carried;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(TABLE_DEPTH)) else $error("entry count above table depth");
	a_chk_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_v_s1 |-> $past(st_q) == B_SCAN) else $error("check outside scan");
	a_cnt_src: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> ($past(st_q) == B_IDLE || $past(st_q) == B_DECIDE))
		else $error("entry count changed mid scan");

endmodule

// ----- sv/rect_list_disjoint_append.sv -----
// Rectangle table with disjoint append.
// req channel (valid/ready): one transfer per request. req_type 1 empties the table;
// req_type 0 scans entries start_index up to end_index (clamped to the entry
// count), skips disjoint ones, flags exact matches and stops at the first
// partial overlap; otherwise the query rectangle is appended, or reported full if the table is full.
// rsp channel (valid/ready): exactly one transfer per request, in request order.
// cfg_we/cfg_wdata: capacity limit; the user must write it only while the block is idle (not enforced).
// Requests pass a registered classify stage and a two-entry queue into the
// scan engine, which reads one table entry per cycle from a single-port RAM.
// The engine takes one request at a time from the queue and accepts the next only
// once it is idle again; the table read port delivers one entry per cycle through
// a registered read.
// Reset empties the table and the queue and sets the capacity limit to 256;
// table contents are not cleared, only the entry count.
// A stalled receiver holds the result register; the engine then waits and the
// queue and input stage fill before req.ready falls.
module rect_list_disjoint_append #(
	parameter int TABLE_DEPTH = rld_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	rld_req_if.sink                   req,
	rld_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [rld_pkg::IDX_W-1:0] cfg_wdata
);
	import rld_pkg::*;

	req_t front_item;
	logic front_valid;
	logic front_ready;
	req_t queue_item;
	logic queue_valid;
	logic queue_ready;

	rld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.item       (front_item),
		.item_valid (front_valid),
		.item_ready (front_ready)
	);

	rld_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_item   (queue_item)
	);

	rld_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pop_valid (queue_valid),
		.pop_ready (queue_ready),
		.pop_item  (queue_item),
		.rsp       (rsp)
	);

endmodule
